@@ src/hllu_pkg.sv @@
// Shared types, constants and helper functions for the HLL register update block.
// Used by hllu_div, hll_register_update_hip and the testbench; depends on nothing.
package hllu_pkg;

   // Sizing of the register store and of the HIP fixed-point format.
   localparam int MAX_LG_K      = 12;
   localparam int HIP_FRAC_BITS = 16;
   localparam int RANK_SPLIT    = 32;
   localparam int LGK_MIN       = 4;

   localparam int LGK_W   = 4;
   localparam int ADDR_W  = MAX_LG_K;
   localparam int DEPTH   = 1 << MAX_LG_K;
   localparam int KEY_W   = 26;
   localparam int RANK_W  = 6;
   localparam int SUM_W   = 45;
   localparam int ZC_W    = 13;
   localparam int ACC_W   = 64;
   localparam int QUO_W   = 64;
   localparam int CNT_W   = $clog2(QUO_W);
   // The rank sum in units of 2^-64: low sum shifted up, plus the high sum.
   localparam int DEN_W   = SUM_W + RANK_SPLIT;

   localparam logic [LGK_W-1:0] LGK_RESET = LGK_W'(12);

   // Sequencer states of the top level.
   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LOOKUP,
      ST_DIVIDE
   } hllu_state_type;

   // Input beat.
   typedef struct packed {
      logic [KEY_W-1:0]  slot_key;
      logic [RANK_W-1:0] rank;
   } hllu_req_type;

   // Result beat.
   typedef struct packed {
      logic              changed;
      logic [ACC_W-1:0]  hip_estimate;
      logic [ZC_W-1:0]   zero_registers;
      logic [SUM_W-1:0]  low_rank_sum;
      logic [SUM_W-1:0]  high_rank_sum;
   } hllu_rsp_type;

   // Clamp the written lg_k into the supported range.
   function automatic logic [LGK_W-1:0] clamp_lgk(input logic [LGK_W-1:0] v);
      logic [LGK_W-1:0] r;
      r = v;
      if (r < LGK_W'(LGK_MIN)) r = LGK_W'(LGK_MIN);
      if (r > LGK_W'(MAX_LG_K)) r = LGK_W'(MAX_LG_K);
      return r;
   endfunction

   // Term 2^-v in the scale of its own sum. Below the split it is 2^(32-v)
   // in the low sum; at or above it, 2^(64-v) in the high sum. Both reduce
   // to a shift by 32 minus the low five bits of the rank.
   function automatic logic [SUM_W-1:0] rank_term(input logic [RANK_W-1:0] v);
      logic [RANK_W-1:0] sh;
      sh = RANK_W'(RANK_SPLIT) - {1'b0, v[4:0]};
      return SUM_W'(1) << sh;
   endfunction

endpackage

@@ src/hllu_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// Stands alone; no package needed.
module hllu_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

@@ src/hllu_div.sv @@
// Radix-2 restoring divider: 2^(lg_k + frac bits + 64) over the rank sum,
// one quotient bit per cycle, saturated to 64 bits. Uses hllu_pkg.
module hllu_div (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [hllu_pkg::LGK_W-1:0]  lgk_eff,
   input  logic [hllu_pkg::DEN_W-1:0]  denom,
   output logic                        done,
   output logic [hllu_pkg::QUO_W-1:0]  quotient
);

   logic                        busy_ff, busy_in;
   logic                        done_ff, done_in;
   logic                        sat_ff, sat_in;
   logic [hllu_pkg::CNT_W-1:0]  cnt_ff, cnt_in;
   logic [hllu_pkg::DEN_W-1:0]  rem_ff, rem_in;
   logic [hllu_pkg::DEN_W-1:0]  den_ff, den_in;
   logic [hllu_pkg::QUO_W-1:0]  quo_ff, quo_in;
   logic [hllu_pkg::DEN_W:0]    trial;
   logic [hllu_pkg::DEN_W:0]    den_ext;
   logic                        fits;

   // One shift-compare-subtract step on the partial remainder.
   assign trial   = {rem_ff, 1'b0};
   assign den_ext = {1'b0, den_ff};
   assign fits    = (trial >= den_ext);

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      sat_in  = sat_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      quo_in  = quo_ff;
      if (start) begin
         // The numerator's upper half is a single bit; its low 64 bits are zero.
         busy_in = 1'b1;
         cnt_in  = '0;
         den_in  = denom;
         rem_in  = hllu_pkg::DEN_W'(1) << (32'(lgk_eff) + hllu_pkg::HIP_FRAC_BITS);
         quo_in  = '0;
         sat_in  = 1'b0;
      end else if (busy_ff) begin
         // On the first step, an upper half at or above the divisor means
         // the quotient does not fit in 64 bits (a zero divisor included).
         if (cnt_ff == '0) begin
            sat_in = (rem_ff >= den_ff);
         end
         rem_in = fits ? hllu_pkg::DEN_W'(trial - den_ext) : trial[hllu_pkg::DEN_W-1:0];
         quo_in = {quo_ff[hllu_pkg::QUO_W-2:0], fits};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == {hllu_pkg::CNT_W{1'b1}}) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      sat_ff <= sat_in;
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      quo_ff <= quo_in;
   end

   assign done     = done_ff;
   assign quotient = sat_ff ? {hllu_pkg::QUO_W{1'b1}} : quo_ff;

endmodule

@@ src/hll_register_update_hip.sv @@
// Top level of the HLL register update with HIP accumulator: sequencer,
// sums, accumulator and store. Uses hllu_pkg, hllu_ram and hllu_div.
//
//   channel   direction  handshake                 beat
//   request   in         start / busy              hllu_req_type
//   result    out        rsp_valid strobe          hllu_rsp_type
//   csr       in         csr_valid / csr_ready     lg_k, 4 bits
//
// An item that does not raise its register has its result registered from
// the lookup state. A raising item goes through lookup, the divider's 64
// one-bit steps and the update. After reset and after every lg_k write, a
// clearing pass zeroes the 4096-entry store, one entry a cycle; busy is
// high throughout the pass. The result strobe lasts one cycle and cannot
// be held off by the receiver.
module hll_register_update_hip (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  hllu_pkg::hllu_req_type      req_coupon,
   output logic                        rsp_valid,
   output hllu_pkg::hllu_rsp_type      rsp_data,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [hllu_pkg::LGK_W-1:0]  csr_data
);

   hllu_pkg::hllu_state_type state_ff, state_in;

   logic [hllu_pkg::LGK_W-1:0]   lgk_ff, lgk_in;
   logic [hllu_pkg::ADDR_W-1:0]  clr_ff, clr_in;
   logic [hllu_pkg::ADDR_W-1:0]  slot_ff, slot_in;
   logic [hllu_pkg::RANK_W-1:0]  rank_ff, rank_in;
   logic [hllu_pkg::RANK_W-1:0]  cur_ff, cur_in;
   logic [hllu_pkg::SUM_W-1:0]   low_ff, low_in;
   logic [hllu_pkg::SUM_W-1:0]   high_ff, high_in;
   logic [hllu_pkg::ACC_W-1:0]   acc_ff, acc_in;
   logic [hllu_pkg::ZC_W-1:0]    zc_ff, zc_in;
   logic                         changed_ff, changed_in;
   logic                         rsp_valid_ff, rsp_valid_in;

   logic                         accept;
   logic                         csr_fire;
   logic                         raise;
   logic                         update;
   logic [hllu_pkg::LGK_W-1:0]   lgk_eff;
   logic [hllu_pkg::LGK_W-1:0]   lgk_new;
   logic [hllu_pkg::ADDR_W:0]    slot_mask;
   logic [hllu_pkg::ADDR_W-1:0]  req_slot;
   logic [hllu_pkg::DEN_W-1:0]   denom;
   logic [hllu_pkg::ACC_W:0]     acc_sum;
   logic [hllu_pkg::SUM_W-1:0]   old_term;
   logic [hllu_pkg::SUM_W-1:0]   new_term;

   logic                         ram_we;
   logic [hllu_pkg::ADDR_W-1:0]  ram_waddr;
   logic [hllu_pkg::RANK_W-1:0]  ram_wdata;
   logic [hllu_pkg::RANK_W-1:0]  ram_rdata;

   logic                         div_start;
   logic                         div_done;
   logic [hllu_pkg::QUO_W-1:0]   div_quo;

   // Handshakes and decoded conditions.
   assign accept   = start && !busy;
   assign csr_fire = csr_valid && csr_ready;
   assign lgk_eff  = hllu_pkg::clamp_lgk(lgk_ff);
   assign lgk_new  = hllu_pkg::clamp_lgk(csr_data);
   assign raise    = (rank_ff > ram_rdata);
   assign update   = (state_ff == hllu_pkg::ST_DIVIDE) && div_done;

   // The slot is the key's low lg_k bits.
   assign slot_mask = ((hllu_pkg::ADDR_W + 1)'(1) << lgk_eff) - 1'b1;
   assign req_slot  = req_coupon.slot_key[hllu_pkg::ADDR_W-1:0]
                      & slot_mask[hllu_pkg::ADDR_W-1:0];

   // Rank sum in units of 2^-64.
   assign denom = {low_ff, {hllu_pkg::RANK_SPLIT{1'b0}}}
                  + hllu_pkg::DEN_W'(high_ff);

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         hllu_pkg::ST_CLEAR: begin
            if (clr_ff == {hllu_pkg::ADDR_W{1'b1}}) state_in = hllu_pkg::ST_IDLE;
         end
         hllu_pkg::ST_IDLE: begin
            if (accept) state_in = hllu_pkg::ST_LOOKUP;
         end
         hllu_pkg::ST_LOOKUP: begin
            state_in = raise ? hllu_pkg::ST_DIVIDE : hllu_pkg::ST_IDLE;
         end
         hllu_pkg::ST_DIVIDE: begin
            if (div_done) state_in = hllu_pkg::ST_IDLE;
         end
         default: begin
            state_in = hllu_pkg::ST_CLEAR;
         end
      endcase
      if (csr_fire) state_in = hllu_pkg::ST_CLEAR;
   end

   // Outputs of the sequencer.
   always_comb begin
      busy         = 1'b1;
      csr_ready    = 1'b0;
      ram_we       = 1'b0;
      ram_waddr    = slot_ff;
      ram_wdata    = rank_ff;
      div_start    = 1'b0;
      rsp_valid_in = 1'b0;
      case (state_ff)
         hllu_pkg::ST_CLEAR: begin
            csr_ready = 1'b1;
            ram_we    = 1'b1;
            ram_waddr = clr_ff;
            ram_wdata = '0;
         end
         hllu_pkg::ST_IDLE: begin
            // A csr beat on offer takes the cycle, so no coupon is taken with it.
            busy      = csr_valid;
            csr_ready = 1'b1;
         end
         hllu_pkg::ST_LOOKUP: begin
            div_start    = raise;
            rsp_valid_in = !raise;
         end
         hllu_pkg::ST_DIVIDE: begin
            ram_we       = div_done;
            rsp_valid_in = div_done;
         end
         default: begin
            busy = 1'b1;
         end
      endcase
   end

   // Term swap and saturating accumulation for a raising item.
   assign old_term = hllu_pkg::rank_term(cur_ff);
   assign new_term = hllu_pkg::rank_term(rank_ff);
   assign acc_sum  = {1'b0, acc_ff} + {1'b0, div_quo};

   // Datapath next values.
   always_comb begin
      lgk_in     = lgk_ff;
      clr_in     = clr_ff;
      slot_in    = slot_ff;
      rank_in    = rank_ff;
      cur_in     = cur_ff;
      low_in     = low_ff;
      high_in    = high_ff;
      acc_in     = acc_ff;
      zc_in      = zc_ff;
      changed_in = changed_ff;
      if (state_ff == hllu_pkg::ST_CLEAR) begin
         clr_in = clr_ff + 1'b1;
      end
      if (accept) begin
         slot_in = req_slot;
         rank_in = req_coupon.rank;
      end
      if (state_ff == hllu_pkg::ST_LOOKUP) begin
         cur_in     = ram_rdata;
         changed_in = 1'b0;
      end
      if (update) begin
         changed_in = 1'b1;
         acc_in     = acc_sum[hllu_pkg::ACC_W] ? {hllu_pkg::ACC_W{1'b1}}
                                               : acc_sum[hllu_pkg::ACC_W-1:0];
         if (cur_ff[hllu_pkg::RANK_W-1] == 1'b0) begin
            if (rank_ff[hllu_pkg::RANK_W-1] == 1'b0) begin
               low_in = low_ff - old_term + new_term;
            end else begin
               low_in  = low_ff - old_term;
               high_in = high_ff + new_term;
            end
         end else begin
            high_in = high_ff - old_term + new_term;
         end
         if ((cur_ff == '0) && (zc_ff != '0)) zc_in = zc_ff - 1'b1;
      end
      // A new lg_k restarts the store from its cleared state.
      if (csr_fire) begin
         lgk_in  = csr_data;
         clr_in  = '0;
         low_in  = hllu_pkg::SUM_W'(1) << (32'(lgk_new) + hllu_pkg::RANK_SPLIT);
         high_in = '0;
         acc_in  = '0;
         zc_in   = hllu_pkg::ZC_W'(1) << lgk_new;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= hllu_pkg::ST_CLEAR;
         clr_ff       <= '0;
         lgk_ff       <= hllu_pkg::LGK_RESET;
         low_ff       <= hllu_pkg::SUM_W'(1)
                         << (32'(hllu_pkg::clamp_lgk(hllu_pkg::LGK_RESET))
                             + hllu_pkg::RANK_SPLIT);
         high_ff      <= '0;
         acc_ff       <= '0;
         zc_ff        <= hllu_pkg::ZC_W'(1) << hllu_pkg::clamp_lgk(hllu_pkg::LGK_RESET);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         lgk_ff       <= lgk_in;
         low_ff       <= low_in;
         high_ff      <= high_in;
         acc_ff       <= acc_in;
         zc_ff        <= zc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      slot_ff    <= slot_in;
      rank_ff    <= rank_in;
      cur_ff     <= cur_in;
      changed_ff <= changed_in;
   end

   // Register store.
   hllu_ram #(
      .WIDTH (hllu_pkg::RANK_W),
      .DEPTH (hllu_pkg::DEPTH)
   ) u_store (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (req_slot),
      .rdata (ram_rdata)
   );

   // Divider for the HIP increment.
   hllu_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .lgk_eff  (lgk_eff),
      .denom    (denom),
      .done     (div_done),
      .quotient (div_quo)
   );

   // Result beat straight from the state registers.
   assign rsp_valid               = rsp_valid_ff;
   assign rsp_data.changed        = changed_ff;
   assign rsp_data.hip_estimate   = acc_ff;
   assign rsp_data.zero_registers = zc_ff;
   assign rsp_data.low_rank_sum   = low_ff;
   assign rsp_data.high_rank_sum  = high_ff;

   // An accepted item always goes to its lookup next.
   a_accept_lookup: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == hllu_pkg::ST_LOOKUP))
      else $error("accepted item did not enter lookup");

   // No result is given while the store is being cleared.
   a_no_rsp_in_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == hllu_pkg::ST_CLEAR) |-> !rsp_valid)
      else $error("result during clearing pass");

   // The divider only finishes while the sequencer waits on it.
   a_div_done_state: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == hllu_pkg::ST_DIVIDE))
      else $error("divider done outside divide state");

   // A raised register never increases the zero count.
   a_zero_count_monotone: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.changed) |-> (zc_ff <= $past(zc_ff)))
      else $error("zero count grew on a raise");

   // A result that did not raise a register leaves the accumulator alone.
   a_acc_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.changed && !$past(csr_fire)) |-> $stable(acc_ff))
      else $error("accumulator moved without a raise");

endmodule

@@ tb/sv/hll_register_update_hip_tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for hll_register_update_hip: coupons from a directed table and then
// random phases at several lg_k settings; each result is checked against its typed row or
// an in-bench HIP sketch. Depends on hllu_pkg and the hll_register_update_hip RTL only.
module hll_register_update_hip_tb;

   localparam int STALL_LIMIT   = 20000;
   localparam int PHASE_ITEMS   = 105;
   localparam int TAIL_CYCLES   = 80;
   localparam int REPORT_LIMIT  = 10;

   typedef enum logic {
      ROW_COUPON,
      ROW_LGK
   } row_kind_type;

   typedef struct {
      row_kind_type                kind;
      logic [hllu_pkg::LGK_W-1:0]  lgk;
      hllu_pkg::hllu_req_type      coupon;
      bit                          typed;
      hllu_pkg::hllu_rsp_type      want;
   } stim_row_type;

   localparam hllu_pkg::hllu_rsp_type UNTYPED = '0;

   logic                         clock;
   logic                         reset;
   logic                         start;
   logic                         busy;
   hllu_pkg::hllu_req_type       req_coupon;
   logic                         rsp_valid;
   hllu_pkg::hllu_rsp_type       rsp_data;
   logic                         csr_valid;
   logic                         csr_ready;
   logic [hllu_pkg::LGK_W-1:0]   csr_data;

   // Shadow copy of the sketch: registers, both rank sums, HIP total, zero count.
   logic [hllu_pkg::RANK_W-1:0]  rank_copy [hllu_pkg::DEPTH];
   logic [63:0]                  low_total;
   logic [63:0]                  high_total;
   logic [63:0]                  hip_total;
   int unsigned                  zeros_left;
   logic [hllu_pkg::LGK_W-1:0]   lgk_value;

   hllu_pkg::hllu_rsp_type       predicted_updates [$];
   stim_row_type                 directed_rows [$];
   int                           mismatches = 0;
   int                           stall_cycles = 0;

   hll_register_update_hip uut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_coupon(req_coupon),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic int unsigned active_lgk();
      int unsigned v;
      v = lgk_value;
      if (v < hllu_pkg::LGK_MIN) v = hllu_pkg::LGK_MIN;
      if (v > hllu_pkg::MAX_LG_K) v = hllu_pkg::MAX_LG_K;
      return v;
   endfunction

   // Empty sketch for the given lg_k, as after reset or a write.
   task automatic clear_sketch(input logic [hllu_pkg::LGK_W-1:0] v);
      lgk_value = v;
      foreach (rank_copy[n]) rank_copy[n] = '0;
      low_total  = 64'd1 << (active_lgk() + 32);
      high_total = '0;
      hip_total  = '0;
      zeros_left = 1 << active_lgk();
   endtask

   // Add or remove the 2^-v term in whichever sum holds it.
   task automatic adjust_sum(input logic [hllu_pkg::RANK_W-1:0] v, input bit add);
      logic [63:0] t;
      if (v < hllu_pkg::RANK_SPLIT) begin
         t = 64'd1 << (32 - v);
         low_total = add ? low_total + t : low_total - t;
      end else begin
         t = 64'd1 << (64 - v);
         high_total = add ? high_total + t : high_total - t;
      end
   endtask

   // One coupon: raise the register if the rank is higher, crediting k / S first.
   task automatic apply_coupon(input hllu_pkg::hllu_req_type c,
                               output hllu_pkg::hllu_rsp_type r);
      int unsigned                  eff;
      logic [hllu_pkg::ADDR_W-1:0]  slot;
      logic [hllu_pkg::RANK_W-1:0]  cur;
      logic [127:0]                 num;
      logic [127:0]                 den;
      logic [127:0]                 quo;
      logic [63:0]                  delta;
      logic [64:0]                  total;
      eff  = active_lgk();
      slot = c.slot_key[hllu_pkg::ADDR_W-1:0] & hllu_pkg::ADDR_W'((1 << eff) - 1);
      cur  = rank_copy[slot];
      r.changed = 1'b0;
      if (c.rank > cur) begin
         den = ({64'd0, low_total} << 32) + {64'd0, high_total};
         num = 128'd1 << (eff + hllu_pkg::HIP_FRAC_BITS + 64);
         if (den == '0) begin
            delta = '1;
         end else begin
            quo   = num / den;
            delta = (quo[127:64] != '0) ? '1 : quo[63:0];
         end
         total     = {1'b0, hip_total} + {1'b0, delta};
         hip_total = total[64] ? '1 : total[63:0];
         adjust_sum(cur, 1'b0);
         adjust_sum(c.rank, 1'b1);
         rank_copy[slot] = c.rank;
         if (cur == '0 && zeros_left != 0) zeros_left--;
         r.changed = 1'b1;
      end
      r.hip_estimate   = hip_total;
      r.zero_registers = zeros_left[hllu_pkg::ZC_W-1:0];
      r.low_rank_sum   = low_total[hllu_pkg::SUM_W-1:0];
      r.high_rank_sum  = high_total[hllu_pkg::SUM_W-1:0];
   endtask

   task automatic add_row(input row_kind_type kind, input logic [hllu_pkg::LGK_W-1:0] lgk,
                          input logic [hllu_pkg::KEY_W-1:0] key,
                          input logic [hllu_pkg::RANK_W-1:0] rank,
                          input bit typed, input hllu_pkg::hllu_rsp_type want);
      stim_row_type row;
      row.kind   = kind;
      row.lgk    = lgk;
      row.coupon = '{slot_key: key, rank: rank};
      row.typed  = typed;
      row.want   = want;
      directed_rows.push_back(row);
   endtask

   // Present one coupon and hold it until the block takes the beat.
   task automatic send_coupon(input hllu_pkg::hllu_req_type c, input bit typed,
                              input hllu_pkg::hllu_rsp_type want);
      hllu_pkg::hllu_rsp_type predicted;
      start      <= 1'b1;
      req_coupon <= c;
      do @(posedge clock); while (busy !== 1'b0);
      apply_coupon(c, predicted);
      predicted_updates.push_back(typed ? want : predicted);
   endtask

   // Hold off the sender until every predicted result has come back.
   task automatic drain_updates();
      start <= 1'b0;
      while (predicted_updates.size() != 0) @(posedge clock);
   endtask

   task automatic write_lgk(input logic [hllu_pkg::LGK_W-1:0] v);
      csr_valid <= 1'b1;
      csr_data  <= v;
      do @(posedge clock); while (csr_ready !== 1'b1);
      csr_valid <= 1'b0;
      clear_sketch(v);
   endtask

   // Geometric ranks like real hashes, plus uniform, zero and very high ranks.
   function automatic logic [hllu_pkg::RANK_W-1:0] pick_rank();
      int unsigned sel;
      int unsigned r;
      sel = $urandom_range(0, 99);
      if (sel < 60) begin
         r = 1;
         while (r < 63 && $urandom_range(0, 1) == 1) r++;
      end else if (sel < 80) begin
         r = $urandom_range(0, 63);
      end else if (sel < 90) begin
         r = 0;
      end else begin
         r = $urandom_range(48, 63);
      end
      return hllu_pkg::RANK_W'(r);
   endfunction

   task automatic check_field(input string field, input logic [63:0] want,
                              input logic [63:0] got);
      if (got !== want) begin
         mismatches++;
         if (mismatches <= REPORT_LIMIT)
            $display("mismatch on %s: expected %h, got %h", field, want, got);
      end
   endtask

   // Each result beat is compared with the oldest prediction.
   always @(posedge clock) begin : result_check
      hllu_pkg::hllu_rsp_type want;
      if (reset === 1'b0 && rsp_valid === 1'b1) begin
         if (predicted_updates.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
               $display("result beat with no update pending: %h", rsp_data);
         end else begin
            want = predicted_updates.pop_front();
            check_field("changed", 64'(want.changed), 64'(rsp_data.changed));
            check_field("hip_estimate", want.hip_estimate, rsp_data.hip_estimate);
            check_field("zero_registers", 64'(want.zero_registers),
                        64'(rsp_data.zero_registers));
            check_field("low_rank_sum", 64'(want.low_rank_sum), 64'(rsp_data.low_rank_sum));
            check_field("high_rank_sum", 64'(want.high_rank_sum),
                        64'(rsp_data.high_rank_sum));
         end
      end
   end

   // Watchdog: give up when no beat of any kind has moved for too long.
   always @(posedge clock) begin
      if ((start === 1'b1 && busy === 1'b0) || rsp_valid === 1'b1 ||
          (csr_valid === 1'b1 && csr_ready === 1'b1))
         stall_cycles <= 0;
      else
         stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   initial begin : stimulus
      logic [hllu_pkg::LGK_W-1:0] lgk_plan [6];
      hllu_pkg::hllu_req_type     c;
      int                         burst_left;
      int                         idle_gap;
      burst_left   = 0;
      reset      <= 1'b1;
      start      <= 1'b0;
      req_coupon <= '0;
      csr_valid  <= 1'b0;
      csr_data   <= '0;
      clear_sketch(hllu_pkg::LGK_RESET);
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed part at the reset lg_k: empty sketch, first raise, both sums.
      add_row(ROW_COUPON, '0, 26'd0, 6'd0, 1'b1,
              hllu_pkg::hllu_rsp_type'{1'b0, 64'd0, 13'd4096, 45'd1 << 44, 45'd0});
      add_row(ROW_COUPON, '0, 26'h3FF_FFFF, 6'd1, 1'b1,
              hllu_pkg::hllu_rsp_type'{1'b1, 64'h1_0000, 13'd4095,
                                       (45'd1 << 44) - (45'd1 << 31), 45'd0});
      add_row(ROW_COUPON, '0, 26'd0, 6'd63, 1'b0, UNTYPED);
      add_row(ROW_COUPON, '0, 26'd1, 6'd32, 1'b0, UNTYPED);
      add_row(ROW_COUPON, '0, 26'd2, 6'd31, 1'b0, UNTYPED);
      // Upper key bits are ignored, so this lands on slot 0 below its stored rank.
      add_row(ROW_COUPON, '0, 26'd4096, 6'd62, 1'b0, UNTYPED);
      // Smallest sketch, driven until the rank sum is tiny and the credit saturates.
      add_row(ROW_LGK, 4'd4, '0, '0, 1'b0, UNTYPED);
      add_row(ROW_COUPON, '0, 26'h3FF_FFC0, 6'd0, 1'b1,
              hllu_pkg::hllu_rsp_type'{1'b0, 64'd0, 13'd16, 45'd1 << 36, 45'd0});
      for (int n = 0; n < 16; n++)
         add_row(ROW_COUPON, '0, 26'h2AA_AAA0 | hllu_pkg::KEY_W'(n), 6'd62, 1'b0, UNTYPED);
      add_row(ROW_COUPON, '0, 26'h3FF_FFF0, 6'd63, 1'b1,
              hllu_pkg::hllu_rsp_type'{1'b1, 64'hFFFF_FFFF_FFFF_FFFF, 13'd0, 45'd0,
                                       45'd62});

      foreach (directed_rows[n]) begin
         if (directed_rows[n].kind == ROW_LGK) begin
            drain_updates();
            write_lgk(directed_rows[n].lgk);
         end else begin
            send_coupon(directed_rows[n].coupon, directed_rows[n].typed,
                        directed_rows[n].want);
         end
      end

      // Random phases, each after a write; out-of-range lg_k values included.
      lgk_plan = '{4'd0, 4'd15, 4'd9, 4'd12, 4'd5, 4'd4};
      foreach (lgk_plan[p]) begin
         drain_updates();
         write_lgk(lgk_plan[p]);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            c.slot_key = hllu_pkg::KEY_W'($urandom);
            c.rank     = pick_rank();
            send_coupon(c, 1'b0, UNTYPED);
            // Bursts with random gaps; the fourth phase skips the gaps but may still drain.
            if (burst_left == 0) begin
               burst_left = $urandom_range(1, 24);
               idle_gap   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 80);
            end else begin
               burst_left--;
               idle_gap = 0;
            end
            if (n != PHASE_ITEMS - 1) begin
               if ($urandom_range(0, 49) == 0) begin
                  drain_updates();
               end else if (idle_gap != 0 && p != 3) begin
                  start <= 1'b0;
                  repeat (idle_gap) @(posedge clock);
               end
            end
         end
      end

      drain_updates();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatches == 0 && predicted_updates.size() == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule

@@ sim.f @@
src/hllu_pkg.sv
src/hllu_ram.sv
src/hllu_div.sv
src/hll_register_update_hip.sv
tb/sv/hll_register_update_hip_tb.sv
